// ----- rtl/bdpc_pkg.sv -----
// Shared types and constants for the button debounce and press classifier.
// Holds per-button state, configuration, event records and register indexes.
// No dependencies.
package bdpc_pkg;

    localparam int BTN_W       = 3;
    localparam int CNT_W       = 8;
    localparam int TIME_W      = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MAX_EVENTS  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI_PRESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEVEL   = 3'd5;

    typedef enum logic [2:0] {
        EV_PRESSED   = 3'd0,
        EV_SHORT     = 3'd1,
        EV_LONG      = 3'd2,
        EV_VERY_LONG = 3'd3,
        EV_MULTI     = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic              pressed;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] press_time;
        logic              long_seen;
        logic              very_long_seen;
        logic [CNT_W-1:0]  click_count;
    } btn_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  debounce_limit;
        logic [TIME_W-1:0] short_press_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] very_long_press_ms;
        logic [TIME_W-1:0] multi_press_ms;
        logic              invert_level;
    } cfg_t;

    typedef struct packed {
        event_kind_t       kind;
        logic [BTN_W-1:0]  button;
        logic [CNT_W-1:0]  value;
    } event_t;

    // Events caused by one sample, slot 0 first
    typedef struct packed {
        logic [1:0]                num;
        event_t [MAX_EVENTS-1:0]   ev;
    } ev_list_t;

endpackage

// ----- rtl/bdpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the per-button state store. No dependencies.
module bdpc_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bdpc_eval.sv -----
// Per-sample evaluation: debounce counter update, press/release decision,
// hold timers and multi-press window. Depends on bdpc_pkg.
module bdpc_eval (
    input  bdpc_pkg::btn_state_t              cur,
    input  bdpc_pkg::cfg_t                    cfg,
    input  logic                              in_range,
    input  logic [bdpc_pkg::BTN_W-1:0]        button,
    input  logic                              raw_level,
    input  logic [bdpc_pkg::TIME_W-1:0]       now_ms,
    output bdpc_pkg::btn_state_t              nxt,
    output bdpc_pkg::ev_list_t                evs
);
    import bdpc_pkg::*;

    logic              level;
    logic [CNT_W:0]    up;
    logic [CNT_W-1:0]  new_count;
    logic              was;
    logic              now_pressed;
    logic [TIME_W-1:0] t_short;
    logic [TIME_W-1:0] t_long;
    logic [TIME_W-1:0] t_very;
    logic [TIME_W-1:0] t_multi;
    logic [1:0]        n;

    // Deadlines wrap at 32 bits
    assign t_short = cur.press_time + cfg.short_press_ms;
    assign t_long  = cur.press_time + cfg.long_press_ms;
    assign t_very  = cur.press_time + cfg.very_long_press_ms;
    assign t_multi = cur.press_time + cfg.multi_press_ms;

    always_comb begin
        level = raw_level ^ cfg.invert_level;
        up    = {1'b0, cur.count} + {{CNT_W{1'b0}}, 1'b1};

        // Saturating up/down debounce counter
        if (level) begin
            new_count = (up < {1'b0, cfg.debounce_limit}) ? up[CNT_W-1:0]
                                                           : cfg.debounce_limit;
        end else if (cur.count != '0) begin
            new_count = cur.count - CNT_W'(1);
        end else begin
            new_count = cur.count;
        end

        was         = cur.pressed;
        now_pressed = was;
        if (was && new_count == '0) begin
            now_pressed = 1'b0;
        end
        if (!was && new_count == cfg.debounce_limit) begin
            now_pressed = 1'b1;
        end

        nxt       = cur;
        nxt.count = new_count;
        evs       = '0;
        n         = 2'd0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            evs.ev[i].button = button;
            evs.ev[i].kind   = EV_PRESSED;
        end

        if (now_pressed != was) begin
            nxt.pressed        = now_pressed;
            nxt.long_seen      = 1'b0;
            nxt.very_long_seen = 1'b0;
            if (now_pressed) begin
                nxt.press_time = now_ms;
                if (cur.click_count != {CNT_W{1'b1}}) begin
                    nxt.click_count = cur.click_count + CNT_W'(1);
                end
                evs.ev[0].kind  = EV_PRESSED;
                evs.ev[0].value = CNT_W'(1);
                evs.ev[1].kind  = EV_MULTI;
                evs.ev[1].value = nxt.click_count;
                n = 2'd2;
            end else begin
                if (now_ms < t_short) begin
                    evs.ev[n].kind  = EV_SHORT;
                    evs.ev[n].value = '0;
                    n = n + 2'd1;
                end
                evs.ev[n].kind  = EV_PRESSED;
                evs.ev[n].value = '0;
                n = n + 2'd1;
            end
        end else begin
            if (was) begin
                if (!cur.long_seen && now_ms > t_long) begin
                    nxt.long_seen   = 1'b1;
                    evs.ev[n].kind  = EV_LONG;
                    evs.ev[n].value = '0;
                    n = n + 2'd1;
                end
                if (!cur.very_long_seen && now_ms > t_very) begin
                    nxt.very_long_seen = 1'b1;
                    evs.ev[n].kind     = EV_VERY_LONG;
                    evs.ev[n].value    = '0;
                    n = n + 2'd1;
                end
            end
            // Released buttons still close the multi-press window
            if (now_ms > t_multi && cur.click_count != '0) begin
                nxt.click_count = '0;
                evs.ev[n].kind  = EV_MULTI;
                evs.ev[n].value = '0;
                n = n + 2'd1;
            end
        end

        evs.num = n;

        // Drop out-of-range samples: no state change, no events
        if (!in_range) begin
            nxt     = cur;
            evs.num = 2'd0;
        end
    end

endmodule

// ----- rtl/bdpc_evq.sv -----
// Event queue: holds the events of one sample and hands them out one per
// cycle while out_ready is high, as the result register. Depends on bdpc_pkg.
module bdpc_evq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  bdpc_pkg::ev_list_t  evs,
    input  logic                out_ready,
    output logic                free,
    output logic                out_valid,
    output bdpc_pkg::event_t    out_event,
    output logic                out_last
);
    import bdpc_pkg::*;

    event_t [MAX_EVENTS-1:0] ev_reg;
    event_t [MAX_EVENTS-1:0] ev_next;
    logic [1:0]              cnt_reg;
    logic [1:0]              cnt_next;
    logic                    take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && out_ready;
    // Free when empty or once the last queued event leaves this cycle
    assign free      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_event = ev_reg[0];
    assign out_last  = (cnt_reg == 2'd1);

    always_comb begin
        ev_next  = ev_reg;
        cnt_next = cnt_reg;
        if (load) begin
            ev_next  = evs.ev;
            cnt_next = evs.num;
        end else if (take) begin
            ev_next[0] = ev_reg[1];
            ev_next[1] = ev_reg[2];
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        ev_reg <= ev_next;
    end

endmodule

// ----- rtl/button_debounce_press_classifier_core.sv -----
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg, bdpc_ram, bdpc_eval and bdpc_evq.
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ------------------------------------------
//  s_        in         s_tvalid/s_tready   s_tdata: button_index, raw_level, now_ms
//  m_        out        m_tvalid/m_tready   m_tdata: event_kind, event_button,
//                                           event_value; m_tlast: last_event
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data (ready out of reset)
//
// Flow: a sample is registered at acceptance while its button's state is read
// from the state RAM; the sample stage then evaluates it and, once the queue is
// free, writes the state back as its events load into the event queue. The first
// event is valid once it is registered in the queue. The queue sends one event
// per cycle while m_tready is high, and a sample raises at most 3 events; samples
// that raise at most one event each are accepted every cycle while m_tready is high.
// Reset: synchronous, active low; s_tready and cfg_ready stay low during reset;
// config returns to defaults and every button reads as released through
// per-entry valid bits, with no clearing pass.
// Stalls: m_tready low holds the queue, which then holds the sample stage.
module button_debounce_press_classifier_core #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Sample input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bdpc_pkg::IN_TDATA_W-1:0]      s_tdata,   // [2:0] button_index,
                                                            // [3] raw_level,
                                                            // [35:4] now_ms, [39:36] 0
    // Event output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bdpc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [2:0] event_kind,
                                                            // [5:3] event_button,
                                                            // [13:6] event_value,
                                                            // [15:14] 0
    output logic                                 m_tlast,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bdpc_pkg::*;

    localparam int IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int STATE_W = $bits(btn_state_t);

    // Configuration registers
    cfg_t cfg_reg;

    // Sample stage
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [BTN_W-1:0]    in_btn_reg;
    logic                in_level_reg;
    logic [TIME_W-1:0]   in_now_reg;

    // Bypass of a state write that lands on the edge the RAM is read
    logic                byp_reg;
    btn_state_t          byp_data_reg;

    logic [NUM_BUTTONS-1:0] valid_reg;

    logic                accept;
    logic                commit;
    logic                q_free;
    logic                in_range;
    logic [IDX_W+BTN_W-1:0] s_idx_ext;
    logic [IDX_W+BTN_W-1:0] in_idx_ext;
    logic [IDX_W-1:0]    s_idx;
    logic [IDX_W-1:0]    in_idx;
    logic                wr_en;
    logic [STATE_W-1:0]  rd_data;
    btn_state_t          cur_state;
    btn_state_t          nxt_state;
    ev_list_t            evs;
    event_t              head;

    // Resize the 3-bit button index to the state depth
    assign s_idx_ext  = {{IDX_W{1'b0}}, s_tdata[BTN_W-1:0]};
    assign in_idx_ext = {{IDX_W{1'b0}}, in_btn_reg};
    assign s_idx      = s_idx_ext[IDX_W-1:0];
    assign in_idx     = in_idx_ext[IDX_W-1:0];
    assign in_range   = (32'(in_btn_reg) < 32'(NUM_BUTTONS));

    // Advance the sample stage when the queue can take its events
    assign commit   = in_valid_reg && q_free;
    // Hold ready low in reset so no transaction is taken and then dropped
    assign s_tready = aresetn && (!in_valid_reg || commit);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = commit && in_range;

    assign cfg_ready = aresetn;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (commit) begin
            in_valid_next = 1'b0;
        end
    end

    // Pick the freshest copy of the button state
    always_comb begin
        if (byp_reg) begin
            cur_state = byp_data_reg;
        end else if (in_range && valid_reg[in_idx]) begin
            cur_state = btn_state_t'(rd_data);
        end else begin
            cur_state = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            valid_reg    <= '0;
            cfg_reg.debounce_limit     <= CNT_W'(5);
            cfg_reg.short_press_ms     <= TIME_W'(500);
            cfg_reg.long_press_ms      <= TIME_W'(1000);
            cfg_reg.very_long_press_ms <= TIME_W'(3000);
            cfg_reg.multi_press_ms     <= TIME_W'(300);
            cfg_reg.invert_level       <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (accept) begin
                byp_reg <= wr_en && (in_idx == s_idx);
            end
            if (wr_en) begin
                valid_reg[in_idx] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit     <= cfg_data[CNT_W-1:0];
                    CFG_SHORT_PRESS:    cfg_reg.short_press_ms     <= cfg_data;
                    CFG_LONG_PRESS:     cfg_reg.long_press_ms      <= cfg_data;
                    CFG_VERY_LONG:      cfg_reg.very_long_press_ms <= cfg_data;
                    CFG_MULTI_PRESS:    cfg_reg.multi_press_ms     <= cfg_data;
                    CFG_INVERT_LEVEL:   cfg_reg.invert_level       <= cfg_data[0];
                    default: ;
                endcase
            end
        end
        // Payload registers
        if (accept) begin
            in_btn_reg   <= s_tdata[BTN_W-1:0];
            in_level_reg <= s_tdata[BTN_W];
            in_now_reg   <= s_tdata[BTN_W+TIME_W:BTN_W+1];
            byp_data_reg <= nxt_state;
        end
    end

    bdpc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (in_idx),
        .wr_data (nxt_state),
        .rd_en   (accept),
        .rd_addr (s_idx),
        .rd_data (rd_data)
    );

    bdpc_eval u_eval (
        .cur       (cur_state),
        .cfg       (cfg_reg),
        .in_range  (in_range),
        .button    (in_btn_reg),
        .raw_level (in_level_reg),
        .now_ms    (in_now_reg),
        .nxt       (nxt_state),
        .evs       (evs)
    );

    bdpc_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (commit),
        .evs       (evs),
        .out_ready (m_tready),
        .free      (q_free),
        .out_valid (m_tvalid),
        .out_event (head),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, head.value, head.button, head.kind};

endmodule
